// ===== rtl/core/apsc_pkg.sv =====
// apsc_pkg: shared widths, register indexes and pipeline types for the
// accelerometer peak step counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package apsc_pkg;

  // Field widths
  localparam int AXIS_W   = 16;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 16;
  localparam int GAP_W    = 16;
  localparam int STEP_W   = 24;
  localparam int CAL_W    = 26;
  localparam int DIST_W   = 27;

  // Squarer lanes: 17-bit signed operand, 32-bit unsigned square
  localparam int LANE_IN_W = AXIS_W + 1;
  localparam int SQ_W      = 32;
  // 100 * |a|^2 of three full-scale axes needs 39 bits
  localparam int MAG_W     = 39;

  // Per-step scale factors (hundredths of a calorie, decimeters)
  localparam int CAL_PER_STEP  = 4;
  localparam int DIST_PER_STEP = 7;

  localparam int COUNT_WIDTH_DEF = 24;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 2'd2;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd9830;
  localparam logic [GAP_W-1:0] MIN_GAP_RST   = 16'd300;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Load enables of the merge stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Threshold compare results
  typedef struct packed {
    logic above;    // |a|^2 > T^2
    logic below08;  // |a| < 0.8 T
    logic below07;  // |a| < 0.7 T
  } mag_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/apsc_sq_lane.sv =====
// apsc_sq_lane: one squarer lane, registered output.
// Depends on apsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsc_sq_lane
  import apsc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [LANE_IN_W-1:0] operand,
  output logic             [SQ_W-1:0]      square
);

  logic signed [2*LANE_IN_W-1:0] prod;

  assign prod = operand * operand;

  // Square of a 17-bit value with |v| <= 65535 always fits 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      square <= prod[SQ_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/apsc_merge.sv =====
// apsc_merge: sums the lane squares and compares the magnitude with
// T^2, 0.64 T^2 and 0.49 T^2 over three registered stages. Depends on apsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module apsc_merge
  import apsc_pkg::*;
(
  input  wire logic             clk,
  input  wire stage_en_t        en,
  input  wire logic [SQ_W-1:0]  sq_x,
  input  wire logic [SQ_W-1:0]  sq_y,
  input  wire logic [SQ_W-1:0]  sq_z,
  input  wire logic [SQ_W-1:0]  thr_sq,
  output mag_flags_t            flags
);

  logic [SQ_W-1:0]  m2;
  logic [SQ_W-1:0]  t2;
  logic [MAG_W-1:0] m2_ext;
  logic [MAG_W-1:0] t2_ext;
  logic [MAG_W-1:0] m100;
  logic [MAG_W-1:0] t64;
  logic [MAG_W-1:0] t49;
  logic             above3;

  assign m2_ext = MAG_W'(m2);
  assign t2_ext = MAG_W'(t2);

  // Stage 2: magnitude squared (sum of three squares stays below 2^32)
  always_ff @(posedge clk) begin
    if (en.s2) begin
      m2 <= sq_x + sq_y + sq_z;
      t2 <= thr_sq;
    end
  end

  // Stage 3: scale both sides so the fractional thresholds compare exactly
  always_ff @(posedge clk) begin
    if (en.s3) begin
      m100   <= (m2_ext << 6) + (m2_ext << 5) + (m2_ext << 2);
      t64    <= t2_ext << 6;
      t49    <= (t2_ext << 5) + (t2_ext << 4) + t2_ext;
      above3 <= (m2 > t2);
    end
  end

  // Stage 4: threshold flags
  always_ff @(posedge clk) begin
    if (en.s4) begin
      flags.above   <= above3;
      flags.below08 <= (m100 < t64);
      flags.below07 <= (m100 < t49);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/accel_peak_step_counter.sv =====
// Accelerometer peak step counter: a request passes the lane stage (loaded on
// the accept edge), then the sum, scale and flag stages and the
// detector/output register, whose load makes the result valid.
// Throughput one request per cycle; each stage stalls only if its successor
// is full, so bubbles are squeezed out while the output waits.
// Reset (rst, synchronous, active high) empties the pipeline, loads the
// configuration defaults and clears the detector state and step count.
`timescale 1ns / 1ps
`default_nettype none

module accel_peak_step_counter
  import apsc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF  // step counter width, 16..32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [79:0]           s_tdata,  // accel_x, accel_y, accel_z, time_ms
  input  wire logic                  s_tuser,  // req_type
  // Result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [79:0]                m_tdata   // step_seen, step_total, calories_centi,
                                               // distance_dm, 2 zero bits
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             enable;
  logic [THR_W-1:0] threshold;
  logic [GAP_W-1:0] min_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      threshold <= THRESHOLD_RST;
      min_gap   <= MIN_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:    enable    <= cfg_wdata[0];
        REG_THRESHOLD: threshold <= cfg_wdata[THR_W-1:0];
        REG_MIN_GAP:   min_gap   <= cfg_wdata[GAP_W-1:0];
        default:       ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  logic signed [AXIS_W-1:0] in_x;
  logic signed [AXIS_W-1:0] in_y;
  logic signed [AXIS_W-1:0] in_z;
  logic        [TIME_W-1:0] in_time;

  assign in_x    = s_tdata[15:0];
  assign in_y    = s_tdata[31:16];
  assign in_z    = s_tdata[47:32];
  assign in_time = s_tdata[79:48];

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its
  // successor takes its contents this cycle.
  // ---------------------------------------------------------------------------
  logic [4:1] vld;       // stage valid bits
  logic [4:1] ld;        // stage load enables
  logic       out_ld;    // output register / detector update enable
  logic       out_vld;

  assign out_ld = !out_vld || m_tready;
  assign ld[4]  = !vld[4] || out_ld;
  assign ld[3]  = !vld[3] || ld[4];
  assign ld[2]  = !vld[2] || ld[3];
  assign ld[1]  = !vld[1] || ld[2];
  assign s_tready = ld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) vld[1] <= s_tvalid;
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
      if (ld[4]) vld[4] <= vld[3];
    end
  end

  // Sideband (request kind, timestamp) rides along with the lanes
  logic [4:1]        req_p;
  logic [TIME_W-1:0] time_p [4:1];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      req_p[1]  <= s_tuser;
      time_p[1] <= in_time;
    end
    for (int k = 2; k <= 4; k++) begin
      if (ld[k]) begin
        req_p[k]  <= req_p[k-1];
        time_p[k] <= time_p[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: four squarer lanes (three axes plus the threshold)
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;
  logic [SQ_W-1:0] sq_z;
  logic [SQ_W-1:0] sq_t;

  apsc_sq_lane u_lane_x (
    .clk     (clk),
    .en      (ld[1]),
    .operand ({in_x[AXIS_W-1], in_x}),
    .square  (sq_x)
  );

  apsc_sq_lane u_lane_y (
    .clk     (clk),
    .en      (ld[1]),
    .operand ({in_y[AXIS_W-1], in_y}),
    .square  (sq_y)
  );

  apsc_sq_lane u_lane_z (
    .clk     (clk),
    .en      (ld[1]),
    .operand ({in_z[AXIS_W-1], in_z}),
    .square  (sq_z)
  );

  // Threshold is unsigned: zero-extend into the signed lane
  apsc_sq_lane u_lane_t (
    .clk     (clk),
    .en      (ld[1]),
    .operand ({1'b0, threshold}),
    .square  (sq_t)
  );

  // ---------------------------------------------------------------------------
  // Stages 2-4: merge lanes and compare against the thresholds
  // ---------------------------------------------------------------------------
  stage_en_t  merge_en;
  mag_flags_t flags;

  assign merge_en.s2 = ld[2];
  assign merge_en.s3 = ld[3];
  assign merge_en.s4 = ld[4];

  apsc_merge u_merge (
    .clk    (clk),
    .en     (merge_en),
    .sq_x   (sq_x),
    .sq_y   (sq_y),
    .sq_z   (sq_z),
    .thr_sq (sq_t),
    .flags  (flags)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: peak detector and step totals. The state updates exactly when
  // the output register loads, so the totals double as the result payload.
  // ---------------------------------------------------------------------------
  logic                   prev_below_valley;
  logic                   in_progress;
  logic [TIME_W-1:0]      last_step_ms;
  logic [COUNT_WIDTH-1:0] step_count;
  logic [DIST_W-1:0]      dist_acc;   // 7 * step_count, modulo 2^27
  logic                   out_seen;

  logic [TIME_W-1:0] gap;
  logic              gap_ok;
  logic              step_hit;
  logic              count_full;

  assign gap        = time_p[4] - last_step_ms;  // wraps modulo 2^32
  assign gap_ok     = gap > TIME_W'(min_gap);
  assign count_full = &step_count;
  assign step_hit   = (req_p[4] == REQ_SAMPLE) && enable && flags.above
                      && !in_progress && gap_ok && prev_below_valley;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld           <= 1'b0;
      prev_below_valley <= 1'b1;
      in_progress       <= 1'b0;
      last_step_ms      <= '0;
      step_count        <= '0;
      dist_acc          <= '0;
    end else if (out_ld) begin
      out_vld <= vld[4];
      if (vld[4]) begin
        if (req_p[4] == REQ_CLEAR) begin
          // clear zeroes the totals only; detector state is kept
          step_count <= '0;
          dist_acc   <= '0;
        end else if (enable) begin
          if (step_hit) begin
            in_progress  <= 1'b1;
            last_step_ms <= time_p[4];
            if (!count_full) begin
              step_count <= step_count + 1'b1;
              dist_acc   <= dist_acc + DIST_W'(DIST_PER_STEP);
            end
          end else if (flags.below07) begin
            in_progress <= 1'b0;
          end
          prev_below_valley <= flags.below08;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && vld[4]) begin
      out_seen <= step_hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Result packing
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0] step_total;
  logic [CAL_W-1:0]  calories_centi;

  assign step_total     = STEP_W'(step_count);
  assign calories_centi = CAL_W'(step_count * CAL_PER_STEP);

  assign m_tvalid = out_vld;
  assign m_tdata  = {2'b00, dist_acc, calories_centi, step_total, out_seen};

`ifndef SYNTHESIS
  // A reported step leaves the detector marked in progress
  a_step_sets_progress: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_seen) |-> in_progress)
    else $error("step reported without in_progress set");

  // Only a clear request may lower the step count
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (out_ld && vld[4] && (req_p[4] == REQ_SAMPLE)) |=> (step_count >= $past(step_count)))
    else $error("step count decreased on a sample");

  // Running distance stays in step with the count
  a_dist_tracks: assert property (@(posedge clk) disable iff (rst)
    dist_acc == DIST_W'(step_count * DIST_PER_STEP))
    else $error("distance accumulator out of step with count");

  // The pipeline never drops a result while the output is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !m_tready) |=> (out_vld && $stable(step_count) && $stable(out_seen)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== verif/step_count_checker.sv =====
// step_count_checker: watches the config, request and result ports of the
// accelerometer peak step counter, predicts each result and compares it.
// Depends on apsc_pkg.
`timescale 1ns / 1ps

module step_count_checker
  import apsc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [79:0]           s_tdata,   // accel_x, accel_y, accel_z, time_ms
  input  logic                  s_tuser,   // req_type
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [79:0]           m_tdata,   // step_seen, step_total, calories_centi,
                                           // distance_dm
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic              seen;
    logic [STEP_W-1:0] total;
    logic [CAL_W-1:0]  cal;
    logic [DIST_W-1:0] distance;
  } step_report_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // register copies
  logic              det_enable;
  logic [THR_W-1:0]  det_threshold;
  logic [GAP_W-1:0]  det_min_gap;
  // detector state
  logic              prev_low;
  logic              peak_active;
  logic [TIME_W-1:0] prior_step_ms;
  logic [COUNT_WIDTH-1:0] step_count;

  step_report_t expected_reports[$];

  function automatic logic [63:0] axis_sq(logic signed [AXIS_W-1:0] a);
    logic signed [63:0] w;
    w = a;
    return w * w;
  endfunction

  // Advances the detector by one request and returns the report it yields.
  function automatic step_report_t advance_detector(logic kind, logic [79:0] data);
    logic [63:0]       mag2, thr2, scaled;
    logic              above, below08, below07;
    logic [TIME_W-1:0] now, since_step;
    step_report_t      r;
    r = '0;
    if (kind == REQ_CLEAR) begin
      step_count = '0;
    end else if (det_enable) begin
      now  = data[79:48];
      mag2 = axis_sq(data[15:0]) + axis_sq(data[31:16]) + axis_sq(data[47:32]);
      thr2 = 64'(det_threshold) * 64'(det_threshold);
      // 0.8 and 0.7 of the threshold, squared, as exact integer ratios
      above   = mag2 > thr2;
      below08 = 64'd100 * mag2 < 64'd64 * thr2;
      below07 = 64'd100 * mag2 < 64'd49 * thr2;
      since_step = now - prior_step_ms;
      if (above && !peak_active && since_step > det_min_gap && prev_low) begin
        r.seen = 1'b1;
        peak_active = 1'b1;
        prior_step_ms = now;
        if (step_count != COUNT_MAX) step_count = step_count + 1'b1;
      end else if (below07) begin
        peak_active = 1'b0;
      end
      prev_low = below08;
    end
    scaled     = 64'(step_count);
    r.total    = scaled[STEP_W-1:0];
    scaled     = 64'(step_count) * CAL_PER_STEP;
    r.cal      = scaled[CAL_W-1:0];
    scaled     = 64'(step_count) * DIST_PER_STEP;
    r.distance = scaled[DIST_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, int want, int got);
    errors++;
    $display("MISMATCH %s: expected %0d, got %0d at %0t", field, want, got, $time);
  endtask

  always @(posedge clk) begin : monitor
    step_report_t got, want;
    if (rst) begin
      det_enable     = 1'b1;
      det_threshold  = THRESHOLD_RST;
      det_min_gap    = MIN_GAP_RST;
      prev_low       = 1'b1;
      peak_active    = 1'b0;
      prior_step_ms  = '0;
      step_count     = '0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:    det_enable    = cfg_wdata[0];
          REG_THRESHOLD: det_threshold = cfg_wdata[THR_W-1:0];
          REG_MIN_GAP:   det_min_gap   = cfg_wdata[GAP_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[24:1], m_tdata[50:25], m_tdata[77:51]};
        if (expected_reports.size() == 0) begin
          report_mismatch("result with none pending, step_total", 0, got.total);
        end else begin
          want = expected_reports.pop_front();
          if (got.seen != want.seen)   report_mismatch("step_seen", want.seen, got.seen);
          if (got.total != want.total) report_mismatch("step_total", want.total, got.total);
          if (got.cal != want.cal)     report_mismatch("calories_centi", want.cal, got.cal);
          if (got.distance != want.distance)
            report_mismatch("distance_dm", want.distance, got.distance);
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(advance_detector(s_tuser, s_tdata));
    end
    pending = expected_reports.size();
  end

endmodule

// ===== verif/accel_peak_step_counter_tb.sv =====
// accel_peak_step_counter_tb: drives requests, config writes and result
// back-pressure into the step counter and gives the verdict.
// Depends on apsc_pkg, accel_peak_step_counter and step_count_checker.
`timescale 1ns / 1ps

module accel_peak_step_counter_tb;
  import apsc_pkg::*;

  // Narrowest counter the block supports
  localparam int CNT_W        = 16;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int PHASES       = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [79:0]           s_tdata;   // accel_x, accel_y, accel_z, time_ms
  logic                  s_tuser;   // req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [79:0]           m_tdata;   // step_seen, step_total, calories_centi, distance_dm

  int errors;
  int pending;

  bit                idling;      // random gaps on the sender and stalls on the receiver
  bit                hold_ready;  // long receiver hold-off in progress
  event              start_holdoff;
  logic [TIME_W-1:0] clock_ms;    // running sample time
  logic [THR_W-1:0]  cur_thr;
  logic [GAP_W-1:0]  cur_gap;
  int                gait_pos;    // 0 valley, 1 rising, 2 peak, 3 falling

  accel_peak_step_counter #(.COUNT_WIDTH(CNT_W)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  step_count_checker #(.COUNT_WIDTH(CNT_W)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the handshakes hang
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  // Result side: ready changes on the falling edge only
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ready) begin
        m_tready = 1'b0;
      end else if (!idling) begin
        m_tready = 1'b1;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Long hold-off, counted here so the sender keeps pushing meanwhile.
  // Flag moves on the rising edge so the receiver sees it race free.
  initial begin : holdoff
    hold_ready = 1'b0;
    forever begin
      @(start_holdoff);
      @(posedge clk);
      hold_ready = 1'b1;
      repeat (400) @(posedge clk);
      hold_ready = 1'b0;
    end
  end

  // One request; returns once it has been accepted
  task automatic send_request(logic kind, logic [15:0] ax, logic [15:0] ay,
                              logic [15:0] az, logic [31:0] stamp);
    int gap;
    gap = idling ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {stamp, az, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic sample_at(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                           logic [31:0] stamp);
    send_request(REQ_SAMPLE, ax, ay, az, stamp);
  endtask

  // Drop valid and wait until every predicted result is out
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Registers only change with the pipe empty
  task automatic set_config(logic en, logic [THR_W-1:0] thr, logic [GAP_W-1:0] gap);
    wait_drain();
    write_reg(REG_ENABLE, {15'd0, en});
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MIN_GAP, gap);
    cur_thr = thr;
    cur_gap = gap;
  endtask

  // Three axes whose magnitude is about pct percent of the threshold,
  // random signs, main component on a random axis
  function automatic logic [47:0] axes_near(int thr, int pct);
    longint      mag, part;
    logic [15:0] main_ax, side_a, side_b;
    mag = longint'(thr) * pct / 100;
    if (mag <= 32767) begin
      main_ax = 16'(mag);
      side_a  = 16'($urandom_range(0, 3));
      side_b  = 16'($urandom_range(0, 3));
    end else begin
      part = mag * 58 / 100;   // ~1/sqrt(3) on each axis
      if (part > 32767) part = 32767;
      main_ax = 16'(part);
      side_a  = main_ax;
      side_b  = main_ax;
    end
    if ($urandom_range(0, 1)) main_ax = -main_ax;
    if ($urandom_range(0, 1)) side_a = -side_a;
    if ($urandom_range(0, 1)) side_b = -side_b;
    case ($urandom_range(0, 2))
      0:       return {side_b, side_a, main_ax};
      1:       return {side_b, main_ax, side_a};
      default: return {main_ax, side_b, side_a};
    endcase
  endfunction

  // Mostly a walking gait (valley, rise, peak, fall) with random levels and
  // timing near the step gap; the rest is clears, noise and broken gait.
  task automatic random_walk(int count, bit keep_idle);
    int          pick, pct;
    logic [47:0] axes;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (!keep_idle && $urandom_range(0, 49) == 0) idling = !idling;
      if (pick < 90) clock_ms += $urandom_range(0, cur_gap / 2 + 40);
      else if (pick < 92) clock_ms = $urandom;
      if (pick < 4) begin
        send_request(REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
      end else if (pick < 14) begin
        sample_at(16'($urandom), 16'($urandom), 16'($urandom), clock_ms);
      end else begin
        case (gait_pos)
          0:       pct = $urandom_range(0, 68);
          2:       pct = $urandom_range(98, 200);
          default: pct = $urandom_range(66, 104);   // straddles 0.7, 0.8 and 1.0
        endcase
        axes = axes_near(cur_thr, pct);
        sample_at(axes[15:0], axes[31:16], axes[47:32], clock_ms);
        if ($urandom_range(0, 9) < 8) gait_pos = (gait_pos + 1) % 4;
        else gait_pos = $urandom_range(0, 3);
      end
    end
  endtask

  initial begin : stimulus
    logic             en;
    logic [THR_W-1:0] thr;
    logic [GAP_W-1:0] gap;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = REQ_SAMPLE;
    idling    = 1'b1;
    gait_pos  = 0;
    clock_ms  = '0;
    cur_thr   = THRESHOLD_RST;
    cur_gap   = MIN_GAP_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed, reset config (threshold 9830, gap 300) ----
    // clear with junk axes and time
    send_request(REQ_CLEAR, 16'hFFFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
    sample_at(16'd0, 16'd0, 16'd0, 32'd100);          // valley
    sample_at(16'd16384, 16'd0, 16'd0, 32'd400);      // first step
    sample_at(16'd7500, 16'd0, 16'd0, 32'd500);       // between 0.7 and 0.8: stays active
    sample_at(16'd16384, 16'd0, 16'd0, 32'd760);      // still active, no step
    sample_at(16'd0, 16'd0, 16'd0, 32'd800);          // releases the peak
    sample_at(-16'sd16384, 16'd0, 16'd0, 32'd700);    // gap exactly the minimum: no step
    sample_at(16'd0, 16'd0, 16'd0, 32'd701);
    sample_at(16'h8000, 16'h8000, 16'h8000, 32'd701); // most negative axes, gap 301: step
    sample_at(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd800); // largest positive, held
    sample_at(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd900); // tiny: clears
    // time wrap: step just before wrap, a step across it, then one more after it
    sample_at(16'd0, 16'd0, 16'd0, 32'hFFFF_FF00);
    sample_at(16'd16384, 16'd0, 16'd0, 32'hFFFF_FF40);
    sample_at(16'd0, 16'd0, 16'd0, 32'hFFFF_FFF0);
    sample_at(16'd16384, 16'd0, 16'd0, 32'h0000_0080);
    sample_at(16'd0, 16'd0, 16'd0, 32'h0000_0100);
    sample_at(16'd16384, 16'd0, 16'd0, 32'h0000_0200);

    // threshold 10: exact ties at 1.0, 0.8 and 0.7 of it
    set_config(1'b1, 16'd10, 16'd0);
    sample_at(16'd0, 16'd0, 16'd0, 32'h300);
    sample_at(16'd10, 16'd0, 16'd0, 32'h301);   // equal: not above
    sample_at(16'd8, 16'd0, 16'd0, 32'h302);    // equal to 0.8: not below
    sample_at(16'd7, 16'd0, 16'd0, 32'h303);    // below 0.8, equal to 0.7
    sample_at(16'd11, 16'd0, 16'd0, 32'h304);   // step
    sample_at(16'd6, 16'd0, 16'd0, 32'h305);    // below 0.7: clears

    // detection off: samples ignored, clear still works
    set_config(1'b0, 16'd10, 16'd0);
    sample_at(16'd11, 16'd0, 16'd0, 32'h400);
    send_request(REQ_CLEAR, 16'd11, 16'd0, 16'd0, 32'h401);

    // zero threshold: nothing is ever below 0.8 or 0.7
    set_config(1'b1, 16'd0, 16'd0);
    sample_at(16'd0, 16'd0, 16'd0, 32'h500);
    sample_at(16'd1, 16'd0, 16'd0, 32'h501);

    // ---- fast peak/valley pairs, back to back, no idling ----
    idling = 1'b0;
    set_config(1'b1, 16'd1000, 16'd0);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 32'd0);
    repeat (16) begin
      clock_ms += 1;
      sample_at(16'd5000, 16'd0, 16'd0, clock_ms);
      clock_ms += 1;
      sample_at(16'd0, 16'd0, 16'd0, clock_ms);
    end
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, clock_ms);
    idling = 1'b1;

    // ---- random phases, each with its own register setting ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin en = 1'b1; thr = THRESHOLD_RST;                  gap = MIN_GAP_RST; end
        1: begin en = 1'b1; thr = 16'($urandom_range(1, 2000));   gap = '0;          end
        3: begin en = 1'b1; thr = 16'hFFFF;                       gap = 16'hFFFF;    end
        4: begin
          en  = ($urandom_range(0, 9) < 7);
          thr = 16'($urandom);
          gap = 16'($urandom_range(0, 600));
        end
        default: begin
          en  = 1'b1;
          thr = 16'($urandom_range(2000, 40000));
          gap = 16'($urandom_range(0, 600));
        end
      endcase
      set_config(en, thr, gap);
      if (p == 2) begin
        // receiver holds off while the sender keeps offering: pipe fills up
        -> start_holdoff;
        idling = 1'b0;
        random_walk(40, 1'b1);
        idling = 1'b1;
      end
      random_walk(RANDOM_ITEMS / PHASES, 1'b0);
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
